// File: hw/rtl/bpf_pkg.sv
// ----------------------------------------------------------------------------
// Boot packet framer package
// Shared types and constants for the boot packet framer modules.
// ----------------------------------------------------------------------------
package bpf_pkg;

  // Item kinds on the input channel.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_START_CODE = 1'b0;
  localparam logic CFG_END_CODE   = 1'b1;

  // Configuration reset values.
  localparam logic [7:0] START_CODE_RST = 8'd0;
  localparam logic [7:0] END_CODE_RST   = 8'd23;

  // Number of header bytes sent for a start request.
  localparam int unsigned HDR_BYTES = 4;

  // One unit of work handed from the decoder to the emitter: a run of body
  // bytes, optionally followed by the packet trailer.
  typedef struct packed {
    logic [HDR_BYTES-1:0][7:0] bytes;     // body bytes, sent from index 0
    logic [1:0]                last_idx;  // index of the last body byte
    logic                      trailer;   // append checksum, end code, padding
    logic [15:0]               check;     // two's-complement checksum
  } job_t;

endpackage

// File: hw/rtl/boot_packet_framer_top.sv
// ----------------------------------------------------------------------------
// Boot packet framer
// Frames bootloader packets into a byte stream cut into bus frames, with a
// header, checksum trailer, end code and zero padding.
// ----------------------------------------------------------------------------
// Path: a request is held in the decoder's job register, and its first byte then
// in the output register, from which it can be taken.
// Throughput: one output byte per cycle while a job is pending and the receiver
// is ready; a payload request yields one byte, a start request four, and a
// closing request adds three plus the pad bytes. The single byte-wide output register sets that rate.
// Reset: synchronous, active low; clears packet state, the frame position and
// the configuration registers (start code 0, end code 23).
module boot_packet_framer_top
  import bpf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 255,
  parameter int FRAME_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_packet_cmd,
  input  logic [7:0] in_payload_length,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic       out_packet_end
);

  logic [7:0] start_code_r;
  logic [7:0] end_code_r;
  logic       job_valid;
  job_t       job;
  logic       job_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      end_code_r   <= END_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_CODE: start_code_r <= cfg_wdata;
        CFG_END_CODE:   end_code_r   <= cfg_wdata;
        default:        start_code_r <= start_code_r;
      endcase
    end
  end

  bpf_decode #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_decode (
    .clk               (clk),
    .rst_n             (rst_n),
    .start_code        (start_code_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_packet_cmd     (in_packet_cmd),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .job_valid         (job_valid),
    .job               (job),
    .job_done          (job_done)
  );

  bpf_emit #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .end_code       (end_code_r),
    .job_valid      (job_valid),
    .job            (job),
    .job_done       (job_done),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_frame_end  (out_frame_end),
    .out_packet_end (out_packet_end)
  );

endmodule

// File: hw/rtl/bpf_decode.sv
// ----------------------------------------------------------------------------
// Boot packet framer decoder
// Accepts input requests, tracks the packet state and the running sum, and
// hands one job per producing request to the emitter.
// ----------------------------------------------------------------------------
module bpf_decode
  import bpf_pkg::*;
#(
  parameter int MAX_PAYLOAD = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] start_code,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_packet_cmd,
  input  logic [7:0] in_payload_length,
  input  logic [7:0] in_data_byte,
  output logic       job_valid,
  output job_t       job,
  input  logic       job_done
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic        in_payload_r, in_payload_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        job_valid_r;
  job_t        job_r, job_nxt;
  logic        make_job;
  logic        accept;
  logic [15:0] len_c;
  logic [15:0] sum_c;
  logic [7:0]  left_dec;

  // The job slot frees when it is empty or the emitter finishes it now.
  assign in_ready = !job_valid_r || job_done;
  assign accept   = in_valid && in_ready;

  // Decode one request into the next packet state and a job.
  always_comb begin
    in_payload_nxt = in_payload_r;
    bytes_left_nxt = bytes_left_r;
    sum_nxt        = sum_r;
    make_job       = 1'b0;
    job_nxt        = '0;
    len_c          = {8'd0, in_payload_length};
    if (len_c > MaxLen) begin
      len_c = MaxLen;
    end
    sum_c    = 16'd0;
    left_dec = bytes_left_r - 8'd1;
    if (in_command == CMD_START) begin
      if (!in_payload_r) begin
        make_job         = 1'b1;
        sum_c            = 16'(start_code) + 16'(in_packet_cmd)
                         + 16'(len_c[7:0]) + 16'(len_c[15:8]);
        job_nxt.bytes[0] = start_code;
        job_nxt.bytes[1] = in_packet_cmd;
        job_nxt.bytes[2] = len_c[7:0];
        job_nxt.bytes[3] = len_c[15:8];
        job_nxt.last_idx = 2'(HDR_BYTES - 1);
        if (len_c == 16'd0) begin
          job_nxt.trailer = 1'b1;
          job_nxt.check   = ~sum_c + 16'd1;
          sum_nxt         = 16'd0;
        end else begin
          in_payload_nxt = 1'b1;
          bytes_left_nxt = len_c[7:0];
          sum_nxt        = sum_c;
        end
      end
    end else begin
      if (in_payload_r) begin
        make_job         = 1'b1;
        sum_c            = sum_r + 16'(in_data_byte);
        job_nxt.bytes[0] = in_data_byte;
        job_nxt.last_idx = 2'd0;
        if (left_dec == 8'd0) begin
          job_nxt.trailer = 1'b1;
          job_nxt.check   = ~sum_c + 16'd1;
          in_payload_nxt  = 1'b0;
          bytes_left_nxt  = 8'd0;
          sum_nxt         = 16'd0;
        end else begin
          bytes_left_nxt = left_dec;
          sum_nxt        = sum_c;
        end
      end
    end
  end

  // Packet state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      bytes_left_r <= 8'd0;
      sum_r        <= 16'd0;
    end else if (accept) begin
      in_payload_r <= in_payload_nxt;
      bytes_left_r <= bytes_left_nxt;
      sum_r        <= sum_nxt;
    end
  end

  // Job register toward the emitter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else if (in_ready) begin
      job_valid_r <= accept && make_job;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r <= job_nxt;
    end
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

  // Outside a packet no payload bytes are pending; inside one, some are.
  a_idle_no_left: assert property (@(posedge clk) disable iff (!rst_n)
    !in_payload_r |-> bytes_left_r == 8'd0)
    else $error("bytes pending while waiting for a start request");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> bytes_left_r != 8'd0)
    else $error("inside a packet with no payload bytes pending");

endmodule

// File: hw/rtl/bpf_emit.sv
// ----------------------------------------------------------------------------
// Boot packet framer emitter
// Walks through the bytes of each job, appends the trailer and padding,
// tracks the position in the bus frame and drives the output register.
// ----------------------------------------------------------------------------
module bpf_emit
  import bpf_pkg::*;
#(
  parameter int FRAME_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] end_code,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_done,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_frame_end,
  output logic       out_packet_end
);

  localparam int PosW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(FRAME_BYTES - 1);

  // Sequencer phases.
  localparam logic [2:0] PH_BODY   = 3'd0;
  localparam logic [2:0] PH_CHK_LO = 3'd1;
  localparam logic [2:0] PH_CHK_HI = 3'd2;
  localparam logic [2:0] PH_END    = 3'd3;
  localparam logic [2:0] PH_PAD    = 3'd4;

  logic [2:0]      phase_r, phase_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [PosW-1:0] pos_r, pos_nxt;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_frame_end_r;
  logic            out_packet_end_r;
  logic            emit;
  logic            finish;
  logic            pkt_end_c;
  logic            frame_end_c;
  logic [7:0]      byte_c;

  // A byte is sent whenever a job is pending and the output slot is free.
  assign emit        = job_valid && (!out_valid_r || out_ready);
  assign frame_end_c = (pos_r == PosLast);
  assign pos_nxt     = frame_end_c ? '0 : pos_r + 1'b1;
  assign job_done    = emit && finish;

  // Select the current byte and the next phase.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    finish    = 1'b0;
    pkt_end_c = 1'b0;
    byte_c    = 8'd0;
    case (phase_r)
      PH_BODY: begin
        byte_c = job.bytes[idx_r];
        if (idx_r == job.last_idx) begin
          idx_nxt = 2'd0;
          if (job.trailer) begin
            phase_nxt = PH_CHK_LO;
          end else begin
            finish = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      PH_CHK_LO: begin
        byte_c    = job.check[7:0];
        phase_nxt = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        byte_c    = job.check[15:8];
        phase_nxt = PH_END;
      end
      PH_END, PH_PAD: begin
        byte_c = (phase_r == PH_END) ? end_code : 8'd0;
        if (frame_end_c) begin
          finish    = 1'b1;
          pkt_end_c = 1'b1;
          phase_nxt = PH_BODY;
        end else begin
          phase_nxt = PH_PAD;
        end
      end
      default: begin
        phase_nxt = PH_BODY;
        idx_nxt   = 2'd0;
      end
    endcase
  end

  // Sequencer and frame position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BODY;
      idx_r   <= 2'd0;
      pos_r   <= '0;
    end else if (emit) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r       <= byte_c;
      out_frame_end_r  <= frame_end_c;
      out_packet_end_r <= pkt_end_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_frame_end  = out_frame_end_r;
  assign out_packet_end = out_packet_end_r;

  // A packet always closes on a frame boundary.
  a_pkt_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_packet_end_r |-> out_frame_end_r)
    else $error("packet end away from a frame boundary");

  // A job is only retired while one is pending.
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_done |-> job_valid)
    else $error("job retired with no job pending");

  // Frame position stays inside the frame.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PosLast)
    else $error("frame position out of range");

endmodule

// File: dv/boot_packet_framer_top_test.sv
// ----------------------------------------------------------------------------
// Boot packet framer testbench
// Feeds start and payload requests through the framer under random sender
// bursts and receiver stalls. A local model works out every framed byte
// (header, checksum trailer, end code and zero padding) as each request is
// accepted, and the output stream is checked byte by byte against it.
// ----------------------------------------------------------------------------
module boot_packet_framer_top_test;
  import bpf_pkg::*;

  localparam int MAX_PAYLOAD   = 255;
  localparam int FRAME_BYTES   = 8;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 36;
  localparam int LONG_LEN      = 40;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic       kind;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] data;
  } framer_req_t;

  typedef struct {
    logic [7:0] value;
    logic       frame_end;
    logic       packet_end;
  } framed_byte_t;

  typedef enum logic [1:0] {RX_FULL, RX_HALF, RX_SPARSE} rx_mode_e;

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       cfg_we            = 1'b0;
  logic       cfg_index         = CFG_START_CODE;
  logic [7:0] cfg_wdata         = 8'h00;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic       in_command        = CMD_START;
  logic [7:0] in_packet_cmd     = 8'h00;
  logic [7:0] in_payload_length = 8'h00;
  logic [7:0] in_data_byte      = 8'h00;
  logic       out_valid;
  logic       out_ready         = 1'b0;
  logic [7:0] out_byte;
  logic       out_frame_end;
  logic       out_packet_end;

  boot_packet_framer_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_packet_cmd    (in_packet_cmd),
    .in_payload_length(in_payload_length),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_frame_end    (out_frame_end),
    .out_packet_end   (out_packet_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Requests waiting to be driven and framed bytes waiting to be seen.
  framer_req_t  pending_reqs[$];
  framed_byte_t expected_bytes[$];
  int           reqs_queued   = 0;
  int           reqs_accepted = 0;
  int           mismatches    = 0;

  // Model state: packet progress, frame position and register copies.
  logic        pkt_open       = 1'b0;
  logic [7:0]  bytes_due      = 8'h00;
  logic [15:0] sum_so_far     = 16'h0000;
  int          frame_fill     = 0;
  logic [7:0]  start_code_cfg = START_CODE_RST;
  logic [7:0]  end_code_cfg   = END_CODE_RST;

  // Append one framed byte and advance the frame position.
  function automatic void emit_byte(input logic [7:0] value, input logic last);
    framed_byte_t fb;
    fb.value      = value;
    fb.frame_end  = (frame_fill + 1 >= FRAME_BYTES);
    fb.packet_end = last;
    expected_bytes.push_back(fb);
    frame_fill = (frame_fill + 1) % FRAME_BYTES;
  endfunction

  function automatic void emit_summed(input logic [7:0] value);
    sum_so_far = sum_so_far + {8'h00, value};
    emit_byte(value, 1'b0);
  endfunction

  // Checksum, end code, then zero bytes up to the frame boundary.
  function automatic void close_packet();
    logic [15:0] check;
    int          pads;
    check = 16'h0000 - sum_so_far;
    emit_byte(check[7:0], 1'b0);
    emit_byte(check[15:8], 1'b0);
    pads = (FRAME_BYTES - (frame_fill + 1) % FRAME_BYTES) % FRAME_BYTES;
    emit_byte(end_code_cfg, pads == 0);
    for (int i = 0; i < pads; i++) begin
      emit_byte(8'h00, i == pads - 1);
    end
    pkt_open   = 1'b0;
    bytes_due  = 8'h00;
    sum_so_far = 16'h0000;
  endfunction

  // Work out the framed bytes that one accepted request produces.
  function automatic void frame_request(input logic kind, input logic [7:0] cmd,
                                        input logic [7:0] len, input logic [7:0] data);
    logic [15:0] clamped;
    if (kind == CMD_START) begin
      // A start while a packet is open is dropped.
      if (pkt_open) return;
      clamped = ({8'h00, len} > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD) : {8'h00, len};
      sum_so_far = 16'h0000;
      emit_summed(start_code_cfg);
      emit_summed(cmd);
      emit_summed(clamped[7:0]);
      emit_summed(clamped[15:8]);
      if (clamped == 16'h0000) begin
        close_packet();
      end else begin
        pkt_open  = 1'b1;
        bytes_due = clamped[7:0];
      end
    end else begin
      // A payload byte with no open packet is dropped.
      if (!pkt_open) return;
      emit_summed(data);
      bytes_due = bytes_due - 8'd1;
      if (bytes_due == 8'h00) close_packet();
    end
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic void queue_req(input logic kind, input logic [7:0] cmd,
                                    input logic [7:0] len, input logic [7:0] data);
    framer_req_t r;
    r.kind = kind;
    r.cmd  = cmd;
    r.len  = len;
    r.data = data;
    pending_reqs.push_back(r);
    reqs_queued++;
  endfunction

  // Mostly complete packets with random content; now and then a stray
  // payload between packets or a stray start inside a packet.
  task automatic queue_packets(input int target);
    int made;
    int len;
    int noise_at;
    made = 0;
    while (made < target) begin
      if ($urandom_range(0, 9) == 0) queue_req(CMD_PAYLOAD, rnd8(), rnd8(), rnd8());
      len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(13, 64))
                                         : int'($urandom_range(0, 12));
      noise_at = ($urandom_range(0, 4) == 0 && len > 0) ? int'($urandom_range(0, len - 1))
                                                        : -1;
      queue_req(CMD_START, rnd8(), 8'(len), rnd8());
      made++;
      for (int i = 0; i < len; i++) begin
        if (i == noise_at) queue_req(CMD_START, rnd8(), rnd8(), rnd8());
        queue_req(CMD_PAYLOAD, rnd8(), rnd8(), rnd8());
        made++;
      end
    end
  endtask

  // Wait until every request is taken and every framed byte has arrived.
  task automatic wait_drained();
    do @(posedge clk);
    while (reqs_accepted != reqs_queued || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_START_CODE) start_code_cfg = value;
    else end_code_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Request driver: bursts of random length with random gaps in between.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_reqs
    framer_req_t nxt;
    logic        offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_request(in_command, in_packet_cmd, in_payload_length, in_data_byte);
        reqs_accepted++;
      end
      if (!in_valid || in_ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          nxt               = pending_reqs.pop_front();
          offer             = 1'b1;
          in_command        <= nxt.kind;
          in_packet_cmd     <= nxt.cmd;
          in_payload_length <= nxt.len;
          in_data_byte      <= nxt.data;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
          end
        end
        in_valid <= offer;
      end
    end
  end

  // Receiver: stretches of full, half or sparse readiness, plus long
  // hold-offs at fixed byte counts so the framer backs up into its input.
  rx_mode_e rx_mode     = RX_FULL;
  int       rx_stretch  = 0;
  int       hold_left   = 0;
  int       bytes_taken = 0;

  always @(posedge clk) begin : drive_ready
    logic rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        bytes_taken++;
        if (bytes_taken == 250 || bytes_taken == 600) hold_left = HOLD_CYCLES;
      end
      if (rx_stretch == 0) begin
        rx_mode    = rx_mode_e'($urandom_range(0, 2));
        rx_stretch = $urandom_range(8, 64);
      end else begin
        rx_stretch--;
      end
      case (rx_mode)
        RX_FULL: begin
          rdy = 1'b1;
        end
        RX_HALF: begin
          rdy = 1'($urandom_range(0, 1));
        end
        default: begin
          rdy = ($urandom_range(0, 3) == 0);
        end
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // Output checker against the oldest expected byte.
  always @(posedge clk) begin : check_bytes
    framed_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected byte %02h frame_end %0b packet_end %0b",
                   out_byte, out_frame_end, out_packet_end);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.value || out_frame_end !== want.frame_end ||
            out_packet_end !== want.packet_end) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected byte %02h fe %0b pe %0b, got %02h fe %0b pe %0b",
                     want.value, want.frame_end, want.packet_end,
                     out_byte, out_frame_end, out_packet_end);
        end
      end
    end
  end

  // Watchdog on cycles with no traffic on any port.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** boot_packet_framer_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus phases, each under its own register setting.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests with the reset register values.
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'hFF);   // payload while idle
    queue_req(CMD_START,   8'h00, 8'h00, 8'h00);   // zero length
    queue_req(CMD_START,   8'hFF, 8'h01, 8'h00);   // end code on the frame edge
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'hFF);
    queue_req(CMD_START,   8'h5A, 8'h03, 8'h00);
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'h00);
    queue_req(CMD_START,   8'hFF, 8'hFF, 8'hFF);   // start inside a packet
    queue_req(CMD_PAYLOAD, 8'hFF, 8'hFF, 8'h80);
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'h7F);
    queue_req(CMD_START,   8'hA5, 8'h04, 8'h00);
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'h01);
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'h02);
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'h04);
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'h08);
    queue_req(CMD_START,   8'h80, 8'h02, 8'h00);   // longest trailer, seven pads
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'hFF);
    queue_req(CMD_PAYLOAD, 8'h00, 8'h00, 8'hFF);
    wait_drained();

    // One long packet.
    write_reg(CFG_START_CODE, 8'hFF);
    write_reg(CFG_END_CODE, 8'h00);
    queue_req(CMD_START, rnd8(), 8'(LONG_LEN), rnd8());
    for (int i = 0; i < LONG_LEN; i++) queue_req(CMD_PAYLOAD, rnd8(), rnd8(), rnd8());
    wait_drained();

    // Random packets under several register settings.
    write_reg(CFG_START_CODE, 8'h00);
    write_reg(CFG_END_CODE, 8'hFF);
    queue_packets(PHASE_ITEMS);
    wait_drained();

    write_reg(CFG_START_CODE, rnd8());
    write_reg(CFG_END_CODE, rnd8());
    queue_packets(PHASE_ITEMS);
    wait_drained();

    write_reg(CFG_START_CODE, rnd8());
    write_reg(CFG_END_CODE, rnd8());
    queue_packets(PHASE_ITEMS);
    wait_drained();

    write_reg(CFG_START_CODE, 8'hAA);
    write_reg(CFG_END_CODE, 8'h55);
    queue_packets(PHASE_ITEMS);
    wait_drained();

    if (mismatches == 0) begin
      $display("** boot_packet_framer_top: PASSED **");
    end else begin
      $display("** boot_packet_framer_top: FAILED **");
    end
    $finish;
  end

endmodule
